>>> design/pairwise_box_overlap_pairs_unit_assert.svh
// ----------------------------------------------------------------------------
// pairwise box overlap pairs unit assertion macros
// Checks on internal state of the top level, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_BOX_OVERLAP_PAIRS_UNIT_ASSERT_SVH
`define PAIRWISE_BOX_OVERLAP_PAIRS_UNIT_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define PBO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define PBO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pbo_pkg.sv
// ----------------------------------------------------------------------------
// pbo_pkg
// Shared types and fixed constants of the box overlap pair finder.
// ----------------------------------------------------------------------------
package pbo_pkg;

  localparam int unsigned FIELD_W     = 32;  // coordinate field width
  localparam int unsigned HE_W        = 31;  // half extent register width
  localparam int unsigned IDX_OUT_W   = 6;   // index field width on the result
  localparam int unsigned MAX_RESULTS = 63;  // results per body at most
  localparam int unsigned HIT_W       = 6;   // holds 0..MAX_RESULTS

  typedef struct packed {
    logic signed [FIELD_W-1:0] x_position;
    logic signed [FIELD_W-1:0] y_position;
    logic                      end_of_frame;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] lower_index;
    logic [IDX_OUT_W-1:0] higher_index;
    logic                 last_of_run;
    logic                 overflow;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_DRAIN = 3'b100
  } pbo_state_t;

endpackage

>>> design/pbo_overlap.sv
// ----------------------------------------------------------------------------
// pbo_overlap
// Overlap test of two square bodies given as offset-binary coordinates.
// ----------------------------------------------------------------------------
module pbo_overlap
  import pbo_pkg::*;
#(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic [COORD_BITS-1:0] a_x,
  input  logic [COORD_BITS-1:0] a_y,
  input  logic [COORD_BITS-1:0] b_x,
  input  logic [COORD_BITS-1:0] b_y,
  input  logic [HE_W:0]         diameter,
  output logic                  hit
);

  localparam int unsigned CMP_W = (COORD_BITS > HE_W + 1) ? COORD_BITS : HE_W + 1;

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;

  // offset binary keeps the differences unsigned and exact
  assign dx = (a_x >= b_x) ? (a_x - b_x) : (b_x - a_x);
  assign dy = (a_y >= b_y) ? (a_y - b_y) : (b_y - a_y);

  assign hit = (CMP_W'(dx) <= CMP_W'(diameter)) && (CMP_W'(dy) <= CMP_W'(diameter));

endmodule

>>> design/pairwise_box_overlap_pairs_unit.sv
// ----------------------------------------------------------------------------
// pairwise_box_overlap_pairs_unit
// A body with n >= 1 bodies stored before it goes through accept, n reads, last
// compare, scan end and drain; the first body of a frame skips reads and last
// compare, a dropped body goes from accept to drain. A pair waits in a holding
// register until the next pair or the drain, then moves into the output
// register. Result stalls stretch scan and drain. Synchronous reset clears body
// count, half extent and handshake state; memory contents are kept.
// ----------------------------------------------------------------------------
module pairwise_box_overlap_pairs_unit
  import pbo_pkg::*;
#(
  parameter int unsigned MAX_BODIES = 64,
  parameter int unsigned COORD_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [HE_W-1:0] cfg_wdata,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_beat_t        in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output out_beat_t       out_data
);

  localparam int unsigned IDX_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BODIES + 1);
  localparam int unsigned MEM_W = 2 * COORD_BITS;
  localparam logic [COORD_BITS-1:0] SIGN_FLIP = {1'b1, {(COORD_BITS-1){1'b0}}};

  // body memory, {x, y} in offset binary
  logic [MEM_W-1:0] mem [MAX_BODIES];

  pbo_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]     held_r, held_nxt;
  logic [HE_W-1:0]      half_extent_r;
  logic [CNT_W-1:0]     cur_r, cur_nxt;
  logic [CNT_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [MEM_W-1:0]     rd_data_r;
  logic [COORD_BITS-1:0] px_r, px_nxt;
  logic [COORD_BITS-1:0] py_r, py_nxt;
  logic [HIT_W-1:0]     hits_r, hits_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [IDX_OUT_W-1:0] pend_lo_r, pend_lo_nxt;
  logic [IDX_OUT_W-1:0] pend_hi_r, pend_hi_nxt;
  logic                 pend_ovf_r, pend_ovf_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_beat_t            out_data_r, out_data_nxt;

  logic [COORD_BITS-1:0] in_x_off;
  logic [COORD_BITS-1:0] in_y_off;
  logic                  mem_we;
  logic                  rd_en;
  logic                  push;
  out_beat_t             push_beat;
  logic                  out_free;
  logic                  ov_hit;
  logic                  hit;
  logic                  blocked;

  assign in_x_off = COORD_BITS'(in_data.x_position) ^ SIGN_FLIP;
  assign in_y_off = COORD_BITS'(in_data.y_position) ^ SIGN_FLIP;

  pbo_overlap #(
    .COORD_BITS (COORD_BITS)
  ) u_overlap (
    .a_x      (px_r),
    .a_y      (py_r),
    .b_x      (rd_data_r[MEM_W-1:COORD_BITS]),
    .b_y      (rd_data_r[COORD_BITS-1:0]),
    .diameter ({half_extent_r, 1'b0}),
    .hit      (ov_hit)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign hit      = cmp_v_r && ov_hit && (hits_r != HIT_W'(MAX_RESULTS));
  // a second hit needs the held one to move out first
  assign blocked  = hit && pend_v_r && !out_free;

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    cur_nxt       = cur_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_v_nxt     = cmp_v_r;
    cmp_idx_nxt   = cmp_idx_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    hits_nxt      = hits_r;
    pend_v_nxt    = pend_v_r;
    pend_lo_nxt   = pend_lo_r;
    pend_hi_nxt   = pend_hi_r;
    pend_ovf_nxt  = pend_ovf_r;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    push          = 1'b0;
    push_beat     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          px_nxt     = in_x_off;
          py_nxt     = in_y_off;
          cur_nxt    = held_r;
          hits_nxt   = '0;
          cmp_v_nxt  = 1'b0;
          rd_idx_nxt = '0;
          if (held_r == CNT_W'(MAX_BODIES)) begin
            // dropped body: one overflow result
            pend_v_nxt   = 1'b1;
            pend_lo_nxt  = '0;
            pend_hi_nxt  = '0;
            pend_ovf_nxt = 1'b1;
            held_nxt     = in_data.end_of_frame ? '0 : held_r;
            state_nxt    = S_DRAIN;
          end else begin
            // stored now; the scan reads only lower entries
            mem_we       = 1'b1;
            pend_v_nxt   = 1'b0;
            pend_ovf_nxt = 1'b0;
            pend_hi_nxt  = IDX_OUT_W'({{IDX_OUT_W{1'b0}}, held_r});
            held_nxt     = in_data.end_of_frame ? '0 : held_r + 1'b1;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!blocked) begin
          if (rd_idx_r < cur_r) begin
            rd_en       = 1'b1;
            cmp_v_nxt   = 1'b1;
            cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
            rd_idx_nxt  = rd_idx_r + 1'b1;
          end else begin
            cmp_v_nxt = 1'b0;
          end
          if (hit) begin
            if (pend_v_r) begin
              push                   = 1'b1;
              push_beat.lower_index  = pend_lo_r;
              push_beat.higher_index = pend_hi_r;
            end
            pend_v_nxt  = 1'b1;
            pend_lo_nxt = IDX_OUT_W'({{IDX_OUT_W{1'b0}}, cmp_idx_r});
            hits_nxt    = hits_r + 1'b1;
          end
          if (!cmp_v_r && (rd_idx_r == cur_r)) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push                   = 1'b1;
          push_beat.lower_index  = pend_lo_r;
          push_beat.higher_index = pend_hi_r;
          push_beat.last_of_run  = 1'b1;
          push_beat.overflow     = pend_ovf_r;
          pend_v_nxt             = 1'b0;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = push_beat;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[held_r[IDX_W-1:0]] <= {in_x_off, in_y_off};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      held_r        <= '0;
      half_extent_r <= '0;
      rd_idx_r      <= '0;
      cmp_v_r       <= 1'b0;
      pend_v_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cmp_v_r     <= cmp_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        half_extent_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    hits_r     <= hits_nxt;
    pend_lo_r  <= pend_lo_nxt;
    pend_hi_r  <= pend_hi_nxt;
    pend_ovf_r <= pend_ovf_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "pairwise_box_overlap_pairs_unit_assert.svh"

  `PBO_ASSERT_NOW(a_held_in_range, 1'b1, held_r <= CNT_W'(MAX_BODIES),
    "body count above capacity")
  `PBO_ASSERT_NOW(a_scan_bounded, state_r == S_SCAN, rd_idx_r <= cur_r,
    "scan read past the current body")
  `PBO_ASSERT_NOW(a_ovf_only_drain, pend_v_r && pend_ovf_r, state_r == S_DRAIN,
    "overflow result held outside drain")
  `PBO_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state_r != S_IDLE,
    "accepted beat did not start work")

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the box overlap pair finder. Bodies are streamed in
// frames with random gaps while the result side stalls at random. Every
// overlapping pair is predicted here, and each result beat is checked in order.
// ----------------------------------------------------------------------------
module tb
  import pbo_pkg::*;
();

  localparam int unsigned BODY_CAP = 64;
  localparam int unsigned SLOT_W = $clog2(BODY_CAP);
  localparam int unsigned EXP_DEPTH = 128;
  localparam int unsigned EXP_PTR_W = $clog2(EXP_DEPTH);
  localparam int unsigned SETTLE_CYCLES = BODY_CAP + 16;
  localparam int unsigned DRAIN_LIMIT = 50000;
  localparam longint unsigned CYCLE_LIMIT = 3000000;
  localparam logic [HE_W-1:0] HALF_EXT_MAX = '1;
  localparam logic [FIELD_W-1:0] COORD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam logic [FIELD_W-1:0] COORD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic [FIELD_W-1:0] SIGN_FLIP = COORD_MIN;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic [HE_W-1:0] cfg_wdata = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  in_beat_t        in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_beat_t       out_data;

  // shadow of the block: stored bodies in offset binary, count and register
  logic [FIELD_W-1:0] x_seen [BODY_CAP];
  logic [FIELD_W-1:0] y_seen [BODY_CAP];
  int unsigned        bodies_in_frame = 0;
  logic [HE_W-1:0]    half_ext_shadow = '0;

  // expected beats in a ring; the predictor moves the write count, the checker the read count
  out_beat_t          exp_ring [EXP_DEPTH];
  int unsigned        exp_wr_cnt = 0;
  int unsigned        exp_rd_cnt = 0;

  int unsigned     err_cnt = 0;
  longint unsigned cycle_cnt = 0;
  bit              no_gaps = 1'b0;
  int unsigned     stall_left = 0;
  bit              stall_now = 1'b0;

  always #5 clk = ~clk;

  pairwise_box_overlap_pairs_unit #(
    .MAX_BODIES(BODY_CAP),
    .COORD_BITS(FIELD_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // mostly no gap, some short ones, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (no_gaps) return 0;
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void exp_add(out_beat_t beat);
    exp_ring[exp_wr_cnt[EXP_PTR_W-1:0]] = beat;
    exp_wr_cnt++;
  endfunction

  // expected pairs for one accepted body, ordered by stored index
  function automatic void predict_pairs(in_beat_t b);
    logic [FIELD_W-1:0] px, py, dx, dy, reach;
    out_beat_t hit;
    int unsigned hits, k;
    px = b.x_position ^ SIGN_FLIP;
    py = b.y_position ^ SIGN_FLIP;
    reach = {half_ext_shadow, 1'b0};
    hits = 0;
    if (bodies_in_frame >= BODY_CAP) begin
      hit = '0;
      hit.last_of_run = 1'b1;
      hit.overflow = 1'b1;
      exp_add(hit);
    end else begin
      for (k = 0; k < bodies_in_frame; k++) begin
        dx = (px >= x_seen[k[SLOT_W-1:0]]) ? px - x_seen[k[SLOT_W-1:0]]
                                           : x_seen[k[SLOT_W-1:0]] - px;
        dy = (py >= y_seen[k[SLOT_W-1:0]]) ? py - y_seen[k[SLOT_W-1:0]]
                                           : y_seen[k[SLOT_W-1:0]] - py;
        if (dx <= reach && dy <= reach && hits < MAX_RESULTS) begin
          hit = '0;
          hit.lower_index = IDX_OUT_W'(k);
          hit.higher_index = IDX_OUT_W'(bodies_in_frame);
          exp_add(hit);
          hits++;
        end
      end
      if (hits > 0)
        exp_ring[EXP_PTR_W'(exp_wr_cnt - 1)].last_of_run = 1'b1;
      x_seen[bodies_in_frame[SLOT_W-1:0]] = px;
      y_seen[bodies_in_frame[SLOT_W-1:0]] = py;
      bodies_in_frame++;
    end
    if (b.end_of_frame) bodies_in_frame = 0;
  endfunction

  // coordinate near a frame center, scaled to the current extent, now and then random or full-scale
  function automatic logic [FIELD_W-1:0] pick_coord(logic [FIELD_W-1:0] center);
    int unsigned r;
    logic [63:0] span, offs;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom();
    if (r == 1) return ($urandom_range(0, 1) != 0) ? COORD_MIN : COORD_MAX;
    span = 64'(half_ext_shadow) * 3 + 2;
    if (span > 64'hffff_ffff) span = 64'hffff_ffff;
    offs = {$urandom(), $urandom()} % (span + 1);
    return center + FIELD_W'(offs) - FIELD_W'(span >> 1);
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_beat_t exp_beat;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_wr_cnt == exp_rd_cnt) begin
        $error("result beat with nothing expected: lower_index %0d higher_index %0d",
               out_data.lower_index, out_data.higher_index);
        err_cnt++;
      end else begin
        exp_beat = exp_ring[exp_rd_cnt[EXP_PTR_W-1:0]];
        exp_rd_cnt++;
        check_field("lower_index", 32'(exp_beat.lower_index), 32'(out_data.lower_index));
        check_field("higher_index", 32'(exp_beat.higher_index),
                    32'(out_data.higher_index));
        check_field("last_of_run", 32'(exp_beat.last_of_run), 32'(out_data.last_of_run));
        check_field("overflow", 32'(exp_beat.overflow), 32'(out_data.overflow));
      end
    end
  end

  // result side back-pressure in segments of random length
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_now = !no_gaps && ($urandom_range(0, 2) == 0);
      stall_left = stall_now ? 1 + gap_len() : $urandom_range(1, 24);
    end
    stall_left--;
    out_stall <= stall_now;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_body(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                           input bit eof);
    in_beat_t b;
    int unsigned gap;
    b.x_position = x;
    b.y_position = y;
    b.end_of_frame = eof;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_pairs(b);
  endtask

  // wait for every expected beat, then let a body with no pairs finish too
  task automatic drain_results();
    int unsigned waited;
    in_valid <= 1'b0;
    waited = 0;
    while (exp_wr_cnt != exp_rd_cnt && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (exp_wr_cnt != exp_rd_cnt) begin
      $error("%0d expected result beats never arrived", exp_wr_cnt - exp_rd_cnt);
      $display("status: fail");
      $finish;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_half_extent(input logic [HE_W-1:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    half_ext_shadow = v;
  endtask

  // random frames, mostly short, now and then past capacity
  task automatic run_frames(input int unsigned n_bodies);
    int unsigned left, len, r, i;
    logic [FIELD_W-1:0] center;
    left = n_bodies;
    while (left > 0) begin
      r = $urandom_range(0, 19);
      if (r < 16) len = $urandom_range(1, 10);
      else if (r < 19) len = $urandom_range(11, 30);
      else len = $urandom_range(BODY_CAP - 4, BODY_CAP + 6);
      if (len > left) len = left;
      center = $urandom();
      for (i = 0; i < len; i++)
        send_body(pick_coord(center), pick_coord(center), i == len - 1);
      left -= len;
    end
  endtask

  task automatic test_directed_edges();
    // zero extent: only exact coincidence overlaps
    set_half_extent('0);
    send_body(0, 0, 1'b0);
    send_body(0, 0, 1'b0);
    send_body(1, 0, 1'b0);
    send_body(1, 0, 1'b0);
    send_body(COORD_MIN, COORD_MIN, 1'b0);
    send_body(COORD_MAX, COORD_MAX, 1'b0);
    send_body(COORD_MIN, COORD_MIN, 1'b1);
    // widest extent: full-scale difference still misses by one
    set_half_extent(HALF_EXT_MAX);
    send_body(COORD_MIN, COORD_MIN, 1'b0);
    send_body(COORD_MAX, COORD_MAX, 1'b0);
    send_body(COORD_MIN + 1, COORD_MIN, 1'b0);
    send_body(COORD_MAX, COORD_MIN, 1'b1);
    send_body(0, 0, 1'b1);
    // several pairs from one body, last flag on the final one
    set_half_extent(HE_W'(10));
    send_body(5, 5, 1'b0);
    send_body(15, 5, 1'b0);
    send_body(25, 25, 1'b0);
    send_body(20, 15, 1'b0);
    send_body(-32'sd20, -32'sd5, 1'b1);
  endtask

  task automatic test_capacity_overflow();
    logic [FIELD_W-1:0] center;
    int unsigned i;
    set_half_extent(HE_W'($urandom_range(50, 500)));
    center = $urandom();
    for (i = 0; i < BODY_CAP + 2; i++)
      send_body(pick_coord(center), pick_coord(center), i == BODY_CAP + 1);
    // count must have cleared after the overflowing frame
    for (i = 0; i < 3; i++)
      send_body(center, center, i == 2);
  endtask

  task automatic test_random_frames();
    set_half_extent('0);
    run_frames(40);
    set_half_extent(HE_W'($urandom_range(1, 64)));
    run_frames(50);
    set_half_extent(HALF_EXT_MAX);
    run_frames(30);
    set_half_extent(HE_W'($urandom_range(0, HALF_EXT_MAX)));
    run_frames(40);
    set_half_extent(HE_W'($urandom_range(100, 100000)));
    no_gaps = 1'b1;
    run_frames(50);
    drain_results();
    no_gaps = 1'b0;
    set_half_extent(HE_W'($urandom_range(1, 1 << 20)));
    run_frames(30);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_capacity_overflow();
    test_random_frames();
    drain_results();
    if (err_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
